[sv/tdvp_pkg.sv]
// Shared types and constants for the trace record packer.
// Used by the front end, the job queue, the back end and the top level.
package tdvp_pkg;

	localparam int unsigned MAX_BATCH_DEF = 4096;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned HEADER_BYTES = 16;
	localparam int unsigned TOTAL_W = 17;
	localparam int unsigned RECS_W = 13;
	localparam logic [7:0] DROP_TAG = 8'hff;
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic        has_rec;
		logic        last;
		logic [63:0] zz_pc;
		logic [63:0] zz_ea;
	} job_t;

	typedef struct packed {
		logic [1:0]         pad;
		logic [RECS_W-1:0]  record_total;
		logic [TOTAL_W-1:0] total_bytes;
		logic [7:0]         code_byte;
	} res_t;

endpackage

[sv/tdvp_front.sv]
// Front end: accepts records, filters, searches the batch key set and builds jobs.
// Depends on tdvp_pkg.
module tdvp_front import tdvp_pkg::*; #(
	parameter int unsigned MAX_BATCH = MAX_BATCH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [63:0]  pc,
	input  logic [63:0]  ea,
	input  logic         last,
	output logic         job_valid,
	input  logic         job_ready,
	output job_t         job
);

	localparam int unsigned AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
	localparam int unsigned CW = $clog2(MAX_BATCH + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BATCH);

	typedef enum logic [1:0] {IDLE, SCAN, PUSH} state_t;

	state_t        state_q;
	logic [63:0]   pc_q, ea_q, key_q, lpc_q, lea_q;
	logic          last_q, rec_q, rdv_q;
	logic [CW-1:0] idx_q, cnt_q;
	logic [63:0]   zpc_q, zea_q;
	logic [63:0]   mem [MAX_BATCH];
	logic [63:0]   rd_q;
	logic          rd_en, wr_en;
	logic [63:0]   dpc, dea;

	assign in_ready = (state_q == IDLE);
	assign job_valid = (state_q == PUSH);
	assign job = '{has_rec: rec_q, last: last_q, zz_pc: zpc_q, zz_ea: zea_q};
	assign dpc = pc_q - lpc_q;
	assign dea = ea_q - lea_q;

	always_comb begin
		rd_en = 1'b0;
		wr_en = 1'b0;
		if (state_q == SCAN && !(rdv_q && rd_q == key_q)) begin
			if (idx_q < cnt_q) begin
				rd_en = 1'b1;
			end else if (!rdv_q && cnt_q < MAXC) begin
				wr_en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[AW-1:0]] <= key_q;
		end
		if (rd_en) begin
			rd_q <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pc_q <= pc;
			ea_q <= ea;
			key_q <= (pc << 16) + {36'd0, ea[27:0]};
		end
		if (wr_en) begin
			zpc_q <= {dpc[62:0], 1'b0} ^ {64{dpc[63]}};
			zea_q <= {dea[62:0], 1'b0} ^ {64{dea[63]}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			last_q <= 1'b0;
			rec_q <= 1'b0;
			rdv_q <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
			lpc_q <= '0;
			lea_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						last_q <= last;
						rec_q <= 1'b0;
						rdv_q <= 1'b0;
						idx_q <= '0;
						if (ea[63:24] == {32'd0, DROP_TAG}) begin
							state_q <= last ? PUSH : IDLE;
						end else begin
							state_q <= SCAN;
						end
					end
				end
				SCAN: begin
					if (rdv_q && rd_q == key_q) begin
						rdv_q <= 1'b0;
						state_q <= last_q ? PUSH : IDLE;
					end else if (idx_q < cnt_q) begin
						idx_q <= idx_q + 1'b1;
						rdv_q <= 1'b1;
					end else if (rdv_q) begin
						rdv_q <= 1'b0;
					end else if (cnt_q < MAXC) begin
						rec_q <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
						lpc_q <= pc_q;
						lea_q <= ea_q;
						state_q <= PUSH;
					end else begin
						state_q <= last_q ? PUSH : IDLE;
					end
				end
				PUSH: begin
					if (job_ready) begin
						if (last_q) begin
							cnt_q <= '0;
							lpc_q <= '0;
							lea_q <= '0;
						end
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

[sv/tdvp_queue.sv]
// Short job queue between the front end and the back end.
// Depends on tdvp_pkg.
module tdvp_queue import tdvp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic push_ready,
	input  job_t wdata,
	output logic pop_valid,
	input  logic pop,
	output job_t rdata
);

	localparam int unsigned PW = $clog2(QDEPTH);

	job_t          buf_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   n_q;

	assign push_ready = (n_q != (PW+1)'(QDEPTH));
	assign pop_valid = (n_q != '0);
	assign rdata = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			buf_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			n_q <= '0;
		end else begin
			if (push && push_ready) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop && pop_valid) begin
				rp_q <= rp_q + 1'b1;
			end
			n_q <= n_q + (PW+1)'(push && push_ready) - (PW+1)'(pop && pop_valid);
		end
	end

endmodule

[sv/tdvp_back.sv]
// Back end: serializes varint bytes and batch summaries into an output register.
// Depends on tdvp_pkg.
module tdvp_back import tdvp_pkg::*; #(
	parameter int unsigned MAX_BATCH = MAX_BATCH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_pop,
	input  job_t job,
	output logic out_valid,
	input  logic out_ready,
	output logic out_kind,
	output logic out_last,
	output res_t out_res
);

	localparam int unsigned BW = $clog2(MAX_BATCH * 20 + HEADER_BYTES + 1);
	localparam int unsigned CW = $clog2(MAX_BATCH + 1);

	typedef enum logic [1:0] {IDLE, EMIT, SUMM} state_t;

	state_t        state_q;
	logic [63:0]   x_q, y_q;
	logic          phase_q, last_q;
	logic [BW-1:0] pb_q;
	logic [CW-1:0] rec_q;
	logic          ov_q;
	logic          free, cont, fire;
	logic [BW-1:0] total;

	assign free = !ov_q || out_ready;
	assign fire = free && (state_q == EMIT || state_q == SUMM);
	assign cont = |x_q[63:7];
	assign job_pop = (state_q == IDLE) && job_valid;
	assign out_valid = ov_q;
	assign total = pb_q + BW'(HEADER_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			phase_q <= 1'b0;
			last_q <= 1'b0;
			pb_q <= '0;
			rec_q <= '0;
			ov_q <= 1'b0;
			out_kind <= KIND_PAYLOAD;
			out_last <= 1'b0;
			out_res <= '0;
			x_q <= '0;
			y_q <= '0;
		end else begin
			if (fire) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (job_valid) begin
						x_q <= job.zz_pc;
						y_q <= job.zz_ea;
						phase_q <= 1'b0;
						last_q <= job.last;
						state_q <= job.has_rec ? EMIT : SUMM;
					end
				end
				EMIT: begin
					if (free) begin
						out_kind <= KIND_PAYLOAD;
						out_res <= '{pad: 2'b00, record_total: '0, total_bytes: '0,
							code_byte: {cont, x_q[6:0]}};
						out_last <= !cont && phase_q && !last_q;
						pb_q <= pb_q + 1'b1;
						if (cont) begin
							x_q <= x_q >> 7;
						end else if (!phase_q) begin
							x_q <= y_q;
							phase_q <= 1'b1;
						end else begin
							rec_q <= rec_q + 1'b1;
							state_q <= last_q ? SUMM : IDLE;
						end
					end
				end
				SUMM: begin
					if (free) begin
						out_kind <= KIND_SUMMARY;
						out_res <= '{pad: 2'b00, record_total: RECS_W'(rec_q),
							total_bytes: total[TOTAL_W-1:0], code_byte: 8'd0};
						out_last <= 1'b1;
						pb_q <= '0;
						rec_q <= '0;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

[sv/trace_dedup_delta_varint_packer.sv]
// Top level of the trace record packer: front end, job queue, back end.
// Depends on tdvp_pkg, tdvp_front, tdvp_queue and tdvp_back.
//
// Channel  Dir  tdata                                       tuser      tlast
// s_*      in   [63:0] instr_addr, [127:64] data_addr       -          batch_end
// m_*      out  [7:0] code_byte, [24:8] total_bytes,        item_kind  run_last
//               [37:25] record_total, [39:38] zero
//
// A kept record is accepted, its key is searched through the key memory's single
// read port, and a job for a new key or a batch end then goes into the queue.
// The back end picks up a job, then sends one byte a cycle while the output is not
// stalled, 2 to 20 per record, plus one summary at the end of each batch.
// Reset clears all control state; the key memory needs no clearing pass.
// Either side may stall; the four-entry queue keeps the two halves apart.
module trace_dedup_delta_varint_packer import tdvp_pkg::*; #(
	parameter int unsigned MAX_BATCH = MAX_BATCH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // instr_addr, data_addr
	input  logic         s_tlast,  // batch_end
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata,  // code_byte, total_bytes, record_total, pad
	output logic         m_tuser,  // item_kind
	output logic         m_tlast   // run_last
);

	logic fq_valid, fq_ready, qb_valid, qb_pop;
	job_t fq_job, qb_job;
	res_t res;

	tdvp_front #(.MAX_BATCH(MAX_BATCH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.pc(s_tdata[63:0]), .ea(s_tdata[127:64]), .last(s_tlast),
		.job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
	);

	tdvp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(fq_valid), .push_ready(fq_ready), .wdata(fq_job),
		.pop_valid(qb_valid), .pop(qb_pop), .rdata(qb_job)
	);

	tdvp_back #(.MAX_BATCH(MAX_BATCH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(qb_valid), .job_pop(qb_pop), .job(qb_job),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_kind(m_tuser), .out_last(m_tlast), .out_res(res)
	);

	assign m_tdata = res;

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast) else $error("summary without run end");
	a_summary_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0) else $error("summary byte set");
	a_payload_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[39:8] == 32'd0) else $error("payload counts set");
	a_queue_push: assert property (@(posedge clk) disable iff (!arst_n)
		fq_valid && !fq_ready |=> fq_valid) else $error("job lost");

endmodule
